FILE: rtl/uer_pkg.sv
// Shared types, codes and reset constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

    localparam int unsigned UER_SCANS_DEFAULT = 8;

    localparam int unsigned SCAN_IDX_W = 7;
    localparam int unsigned COUNT_W    = 24;
    localparam int unsigned TRIG_W     = 16;
    localparam int unsigned LISTEN_W   = 24;
    localparam int unsigned TPC_W      = 16;
    localparam int unsigned DIST_W     = 10;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [TRIG_W-1:0]   TRIGGER_TICKS_RST = 16'd240;
    localparam logic [LISTEN_W-1:0] LISTEN_TICKS_RST  = 24'd660000;
    localparam logic [TPC_W-1:0]    TICKS_PER_CM_RST  = 16'd1392;
    localparam logic [DIST_W-1:0]   MAX_DISTANCE_RST  = 10'd300;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CM  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_TRIG   = 2'd1,
        PH_LISTEN = 2'd2
    } t_phase;

    typedef struct packed {
        logic [TRIG_W-1:0]   trigger_ticks;
        logic [LISTEN_W-1:0] listen_ticks;
        logic [TPC_W-1:0]    ticks_per_cm;
        logic [DIST_W-1:0]   max_distance;
    } t_cfg;

    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] dist_cm;
    } t_result;

endpackage

FILE: rtl/uer_scan.sv
// Scan sequencer: trigger, listen window, echo timing and averaging for one tick.
`timescale 1ns / 1ps

module uer_scan #(
    parameter int unsigned SCANS = uer_pkg::UER_SCANS_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_start,
    input  logic             i_echo,
    input  uer_pkg::t_cfg    i_cfg,
    output uer_pkg::t_result o_res
);
    import uer_pkg::*;

    // floor(n / SCANS) as (n * DIV_MUL) >> DIV_SHIFT, exact for 16-bit n
    localparam int unsigned DIV_SHIFT = SUM_W + SCAN_IDX_W;
    localparam int unsigned DIV_MUL_W = DIV_SHIFT + 1;
    localparam int unsigned PROD_W    = SUM_W + DIV_MUL_W;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'(((64'd1 << DIV_SHIFT) + 64'(SCANS) - 64'd1) / 64'(SCANS));
    localparam logic [SCAN_IDX_W-1:0] SCANS_C = SCAN_IDX_W'(SCANS);

    t_phase                r_phase, n_phase;
    logic [COUNT_W-1:0]    r_phase_count, n_phase_count;
    logic [SCAN_IDX_W-1:0] r_scan_index, n_scan_index;
    logic                  r_echo_prev, n_echo_prev;
    logic                  r_in_pulse, n_in_pulse;
    logic [TPC_W-1:0]      r_cm_prescale, n_cm_prescale;
    logic [DIST_W-1:0]     r_pulse_cm, n_pulse_cm;
    logic [DIST_W-1:0]     r_captured_cm, n_captured_cm;
    logic                  r_have_echo, n_have_echo;
    logic [SUM_W-1:0]      r_distance_sum, n_distance_sum;

    logic                  v_rise;
    logic                  v_fall;
    logic [DIST_W-1:0]     v_scan_cm;
    logic [PROD_W-1:0]     v_prod;

    always_comb begin
        n_phase        = r_phase;
        n_phase_count  = r_phase_count;
        n_scan_index   = r_scan_index;
        n_in_pulse     = r_in_pulse;
        n_cm_prescale  = r_cm_prescale;
        n_pulse_cm     = r_pulse_cm;
        n_captured_cm  = r_captured_cm;
        n_have_echo    = r_have_echo;
        n_distance_sum = r_distance_sum;
        v_rise         = i_echo & ~r_echo_prev;
        v_fall         = ~i_echo & r_echo_prev;
        v_scan_cm      = '0;
        v_prod         = '0;
        o_res          = '0;

        if (!(r_phase == PH_TRIG || r_phase == PH_LISTEN)) begin
            n_phase = PH_IDLE;
            if (i_start) begin
                n_phase        = PH_TRIG;
                n_phase_count  = '0;
                n_scan_index   = '0;
                n_distance_sum = '0;
            end
        end

        case (n_phase)
            PH_TRIG: begin
                o_res.trig    = 1'b1;
                n_phase_count = n_phase_count + COUNT_W'(1);
                if (n_phase_count >= COUNT_W'(i_cfg.trigger_ticks)) begin
                    // open the listen window
                    n_phase       = PH_LISTEN;
                    n_phase_count = '0;
                    n_in_pulse    = 1'b0;
                    n_cm_prescale = '0;
                    n_pulse_cm    = '0;
                    n_captured_cm = '0;
                    n_have_echo   = 1'b0;
                end
            end
            PH_LISTEN: begin
                if (v_rise) begin
                    n_in_pulse    = 1'b1;
                    n_cm_prescale = '0;
                    n_pulse_cm    = '0;
                end
                if (n_in_pulse && i_echo) begin
                    n_cm_prescale = n_cm_prescale + TPC_W'(1);
                    if (n_cm_prescale >= i_cfg.ticks_per_cm) begin
                        n_cm_prescale = '0;
                        if (n_pulse_cm < i_cfg.max_distance) begin
                            n_pulse_cm = n_pulse_cm + DIST_W'(1);
                        end
                    end
                end
                if (v_fall && n_in_pulse) begin
                    n_captured_cm = n_pulse_cm;
                    n_have_echo   = 1'b1;
                    n_in_pulse    = 1'b0;
                end
                n_phase_count = n_phase_count + COUNT_W'(1);
                if (n_phase_count >= i_cfg.listen_ticks) begin
                    v_scan_cm = n_have_echo ? n_captured_cm : i_cfg.max_distance;
                    if (v_scan_cm > i_cfg.max_distance) begin
                        v_scan_cm = i_cfg.max_distance;
                    end
                    n_distance_sum = n_distance_sum + SUM_W'(v_scan_cm);
                    n_scan_index   = n_scan_index + SCAN_IDX_W'(1);
                    if (n_scan_index >= SCANS_C) begin
                        v_prod        = PROD_W'(n_distance_sum) * PROD_W'(DIV_MUL);
                        o_res.done    = 1'b1;
                        o_res.dist_cm = v_prod[DIV_SHIFT +: DIST_W];
                        n_phase       = PH_IDLE;
                        n_phase_count = '0;
                        n_scan_index  = '0;
                        n_in_pulse    = 1'b0;
                    end else begin
                        n_phase       = PH_TRIG;
                        n_phase_count = '0;
                    end
                end
            end
            default: ;
        endcase

        n_echo_prev = i_echo;
        o_res.busy  = (n_phase == PH_TRIG) || (n_phase == PH_LISTEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_phase_count  <= '0;
            r_scan_index   <= '0;
            r_echo_prev    <= 1'b0;
            r_in_pulse     <= 1'b0;
            r_cm_prescale  <= '0;
            r_pulse_cm     <= '0;
            r_captured_cm  <= '0;
            r_have_echo    <= 1'b0;
            r_distance_sum <= '0;
        end else if (i_adv) begin
            r_phase        <= n_phase;
            r_phase_count  <= n_phase_count;
            r_scan_index   <= n_scan_index;
            r_echo_prev    <= n_echo_prev;
            r_in_pulse     <= n_in_pulse;
            r_cm_prescale  <= n_cm_prescale;
            r_pulse_cm     <= n_pulse_cm;
            r_captured_cm  <= n_captured_cm;
            r_have_echo    <= n_have_echo;
            r_distance_sum <= n_distance_sum;
        end
    end

    a_scan_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_index < SCANS_C)
        else $error("scan index reached the scan count");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_start && r_phase == PH_IDLE) |=> (r_phase != PH_IDLE))
        else $error("accepted start left the sequencer idle");

    a_hold_without_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> ($stable(r_phase) && $stable(r_phase_count)
                    && $stable(r_distance_sum)))
        else $error("scan state moved without a request");

endmodule

FILE: rtl/ultrasonic_echo_ranger.sv
// A request is held in the input register, and its result is then written to the result
// register; one request is taken every cycle while the result side is not stalled, as
// the scan state updates on each advance.
// The result register parts the two sides, so a stalled result does not stop intake
// until the input register is also full.
// Reset (synchronous, active low) idles the sequencer, clears both pipeline stages and
// restores the configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
    parameter int unsigned SCANS = uer_pkg::UER_SCANS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_start_req,
    input  logic                           i_echo_level,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_trigger_out,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic [uer_pkg::DIST_W-1:0]     o_distance_cm,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import uer_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    r_start;
    logic    r_echo;
    logic    r_out_valid;
    t_result r_out;
    t_result w_res;
    logic    w_adv;

    // advance the held request when the result register is free or draining
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks <= TRIGGER_TICKS_RST;
            r_cfg.listen_ticks  <= LISTEN_TICKS_RST;
            r_cfg.ticks_per_cm  <= TICKS_PER_CM_RST;
            r_cfg.max_distance  <= MAX_DISTANCE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TRIGGER_TICKS: r_cfg.trigger_ticks <= i_cfg_data[TRIG_W-1:0];
                CFG_LISTEN_TICKS:  r_cfg.listen_ticks  <= i_cfg_data[LISTEN_W-1:0];
                CFG_TICKS_PER_CM:  r_cfg.ticks_per_cm  <= i_cfg_data[TPC_W-1:0];
                CFG_MAX_DISTANCE:  r_cfg.max_distance  <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_start <= i_start_req;
            r_echo  <= i_echo_level;
        end
    end

    uer_scan #(
        .SCANS (SCANS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_start (r_start),
        .i_echo  (r_echo),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_trigger_out = r_out.trig;
    assign o_busy_res    = r_out.busy;
    assign o_done_res    = r_out.done;
    assign o_distance_cm = r_out.dist_cm;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> r_in_valid)
        else $error("held request dropped before it advanced");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced request produced no result");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done) |-> (!r_out.busy && !r_out.trig))
        else $error("done result still busy or triggering");

endmodule

FILE: bench/tb_ultrasonic_echo_ranger.sv
// Self-checking bench for the ultrasonic echo ranger: echo tick stream in, per-tick status out.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;

    import uer_pkg::*;

    localparam int unsigned SCANS         = UER_SCANS_DEFAULT;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned REPORT_LIMIT  = 50;

    // Tracks the ranger's sequencer tick by tick and holds the status words still owed.
    class ranging_tracker;
        logic [TRIG_W-1:0]     trig_len;
        logic [LISTEN_W-1:0]   listen_len;
        logic [TPC_W-1:0]      ticks_cm;
        logic [DIST_W-1:0]     max_cm;
        t_phase                phase;
        logic [COUNT_W-1:0]    phase_ticks;
        logic [SCAN_IDX_W-1:0] scan_no;
        logic                  echo_d;
        logic                  in_pulse;
        logic                  have_echo;
        logic [TPC_W-1:0]      prescale;
        logic [DIST_W-1:0]     pulse_cm;
        logic [DIST_W-1:0]     captured_cm;
        logic [SUM_W-1:0]      sum_cm;
        t_result               pending[$];
        int unsigned           mismatches;
        int unsigned           done_seen;

        function new();
            trig_len    = TRIGGER_TICKS_RST;
            listen_len  = LISTEN_TICKS_RST;
            ticks_cm    = TICKS_PER_CM_RST;
            max_cm      = MAX_DISTANCE_RST;
            phase       = PH_IDLE;
            phase_ticks = '0;
            scan_no     = '0;
            echo_d      = 1'b0;
            in_pulse    = 1'b0;
            have_echo   = 1'b0;
            prescale    = '0;
            pulse_cm    = '0;
            captured_cm = '0;
            sum_cm      = '0;
            mismatches  = 0;
            done_seen   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TRIGGER_TICKS: trig_len   = data[TRIG_W-1:0];
                CFG_LISTEN_TICKS:  listen_len = data[LISTEN_W-1:0];
                CFG_TICKS_PER_CM:  ticks_cm   = data[TPC_W-1:0];
                CFG_MAX_DISTANCE:  max_cm     = data[DIST_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic start, logic echo);
            t_result          status;
            logic             rise;
            logic             fall;
            logic [DIST_W-1:0] scan_cm;
            status = '0;
            if (phase != PH_TRIG && phase != PH_LISTEN) begin
                phase = PH_IDLE;
                if (start) begin
                    phase       = PH_TRIG;
                    phase_ticks = '0;
                    scan_no     = '0;
                    sum_cm      = '0;
                end
            end
            if (phase == PH_TRIG) begin
                status.trig = 1'b1;
                phase_ticks = phase_ticks + COUNT_W'(1);
                if (phase_ticks >= COUNT_W'(trig_len)) begin
                    phase       = PH_LISTEN;
                    phase_ticks = '0;
                    in_pulse    = 1'b0;
                    prescale    = '0;
                    pulse_cm    = '0;
                    captured_cm = '0;
                    have_echo   = 1'b0;
                end
            end else if (phase == PH_LISTEN) begin
                rise = echo && !echo_d;
                fall = !echo && echo_d;
                if (rise) begin
                    in_pulse = 1'b1;
                    prescale = '0;
                    pulse_cm = '0;
                end
                if (in_pulse && echo) begin
                    prescale = prescale + TPC_W'(1);
                    if (prescale >= ticks_cm) begin
                        prescale = '0;
                        if (pulse_cm < max_cm) pulse_cm = pulse_cm + DIST_W'(1);
                    end
                end
                if (fall && in_pulse) begin
                    captured_cm = pulse_cm;
                    have_echo   = 1'b1;
                    in_pulse    = 1'b0;
                end
                phase_ticks = phase_ticks + COUNT_W'(1);
                if (phase_ticks >= listen_len) begin
                    // clamp a stale capture to the limit in force now
                    scan_cm = have_echo ? captured_cm : max_cm;
                    if (scan_cm > max_cm) scan_cm = max_cm;
                    sum_cm  = sum_cm + SUM_W'(scan_cm);
                    scan_no = scan_no + SCAN_IDX_W'(1);
                    if (scan_no >= SCAN_IDX_W'(SCANS)) begin
                        status.done    = 1'b1;
                        status.dist_cm = DIST_W'(sum_cm / SUM_W'(SCANS));
                        phase          = PH_IDLE;
                        phase_ticks    = '0;
                        scan_no        = '0;
                        in_pulse       = 1'b0;
                    end else begin
                        phase       = PH_TRIG;
                        phase_ticks = '0;
                    end
                end
            end
            echo_d      = echo;
            status.busy = (phase == PH_TRIG || phase == PH_LISTEN);
            pending.push_back(status);
        endfunction

        function void match_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            end
        endfunction

        function void check_status(logic trig, logic busy, logic done,
                                   logic [DIST_W-1:0] dist_cm);
            t_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: status expected none, got trig %0b busy %0b done %0b dist %0d",
                             $time, trig, busy, done, dist_cm);
                return;
            end
            want = pending.pop_front();
            if (want.done) done_seen++;
            match_field("trigger_out", 32'(want.trig), 32'(trig));
            match_field("busy_res", 32'(want.busy), 32'(busy));
            match_field("done_res", 32'(want.done), 32'(done));
            match_field("distance_cm", 32'(want.dist_cm), 32'(dist_cm));
        endfunction
    endclass

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_ready;
    logic                  i_start_req  = 1'b0;
    logic                  i_echo_level = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready  = 1'b0;
    logic                  o_trigger_out;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic [DIST_W-1:0]     o_distance_cm;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    ranging_tracker trk;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned rx_hold_seq    = 0;
    int unsigned rx_hold_seen   = 0;
    int unsigned rx_hold_left   = 0;
    int unsigned ticks_sent     = 0;
    int unsigned cycles_run     = 0;
    int unsigned cfg_trig;
    int unsigned cfg_listen;
    int unsigned cfg_tpc;
    int unsigned cfg_max;
    bit          echo_now       = 1'b0;
    int unsigned echo_run       = 0;

    ultrasonic_echo_ranger #(
        .SCANS(SCANS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_start_req   (i_start_req),
        .i_echo_level  (i_echo_level),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_trigger_out (o_trigger_out),
        .o_busy_res    (o_busy_res),
        .o_done_res    (o_done_res),
        .o_distance_cm (o_distance_cm),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    function automatic bit chance(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles_run++;
        if (cycles_run > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (rx_hold_seq != rx_hold_seen) begin
            rx_hold_seen = rx_hold_seq;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !chance(recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                trk.note_tick(i_start_req, i_echo_level);
            if (o_out_valid && i_out_ready)
                trk.check_status(o_trigger_out, o_busy_res, o_done_res, o_distance_cm);
        end
    end

    // Echo waveform as alternating runs of random length
    function automatic bit next_echo(input int unsigned longest);
        if (echo_run == 0) begin
            echo_now = !echo_now;
            echo_run = $urandom_range(1, longest);
        end
        echo_run--;
        return echo_now;
    endfunction

    task automatic send_tick(input bit start, input bit echo);
        int unsigned gap;
        gap = 0;
        while (gap < 20 && chance(send_idle_pct)) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_req  <= start;
        i_echo_level <= echo;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ticks_sent++;
    endtask

    // Hold the input until every owed status word is back, then let the pipe settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (trk.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        trk.set_register(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_config(input int unsigned trig, input int unsigned listen,
                                input int unsigned tpc, input int unsigned maxd);
        write_reg(CFG_TRIGGER_TICKS, CFG_DATA_W'(trig));
        write_reg(CFG_LISTEN_TICKS, CFG_DATA_W'(listen));
        write_reg(CFG_TICKS_PER_CM, CFG_DATA_W'(tpc));
        write_reg(CFG_MAX_DISTANCE, CFG_DATA_W'(maxd));
    endtask

    task automatic run_measurement();
        int unsigned           span;
        int unsigned           disturb_at;
        logic [CFG_IDX_W-1:0]  sel;
        int unsigned           top;
        int unsigned           keep;
        int unsigned           val;
        repeat ($urandom_range(0, 3)) send_tick(1'b0, next_echo(cfg_listen));
        // mostly a proper start; now and then the run opens without one
        if (!chance(8)) send_tick(1'b1, next_echo(cfg_listen));
        span = SCANS * (cfg_trig + cfg_listen) + $urandom_range(0, 4) - 1;
        disturb_at = chance(30) ? $urandom_range(1, span) : 0;
        for (int unsigned k = 1; k <= span; k++) begin
            if (k == disturb_at) begin
                sel = CFG_IDX_W'($urandom_range(0, 3));
                case (sel)
                    CFG_TRIGGER_TICKS: begin top = 65535;    keep = cfg_trig;   end
                    CFG_LISTEN_TICKS:  begin top = 16777215; keep = cfg_listen; end
                    CFG_TICKS_PER_CM:  begin top = 65535;    keep = cfg_tpc;    end
                    default:           begin top = 1023;     keep = cfg_max;    end
                endcase
                case ($urandom_range(0, 4))
                    0, 1:    val = 1;
                    2, 3:    val = top;
                    default: val = $urandom_range(1, top);
                endcase
                // change a register mid-measurement for a few ticks, then restore it
                write_reg(sel, CFG_DATA_W'(val));
                repeat ($urandom_range(1, 8)) send_tick(chance(3), next_echo(cfg_listen));
                write_reg(sel, CFG_DATA_W'(keep));
            end
            send_tick(chance(3), next_echo(cfg_listen));
        end
    endtask

    task automatic run_random_phase();
        cfg_trig   = chance(80) ? $urandom_range(1, 3) : $urandom_range(4, 12);
        cfg_listen = chance(85) ? $urandom_range(2, 16) : $urandom_range(17, 40);
        cfg_tpc    = chance(75) ? $urandom_range(1, 3) : $urandom_range(1, 65535);
        cfg_max    = chance(50) ? $urandom_range(1, 12) : $urandom_range(1, 1023);
        write_config(cfg_trig, cfg_listen, cfg_tpc, cfg_max);
        repeat ($urandom_range(2, 4)) run_measurement();
    endtask

    initial begin
        int unsigned base;
        trk = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle tick under reset configuration
        send_tick(1'b0, 1'b0);

        // shortest trigger and window: eight scans of one trigger tick and one listen tick, start while busy ignored
        write_config(1, 1, 1, 1023);
        send_tick(1'b1, 1'b1);
        for (int k = 0; k < 15; k++) send_tick(k == 4, k[0]);
        send_tick(1'b0, 1'b0);

        // echo high at window open, one full pulse, then a limit drop before the window closes
        write_reg(CFG_LISTEN_TICKS, CFG_DATA_W'(6));
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        write_reg(CFG_MAX_DISTANCE, CFG_DATA_W'(1));
        send_tick(1'b0, 1'b1);

        // longest trigger and window, cut short mid-phase
        write_reg(CFG_TRIGGER_TICKS, CFG_DATA_W'(65535));
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        write_reg(CFG_LISTEN_TICKS, CFG_DATA_W'(16777215));
        write_reg(CFG_TRIGGER_TICKS, CFG_DATA_W'(1));
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        write_reg(CFG_TICKS_PER_CM, CFG_DATA_W'(65535));
        send_tick(1'b0, 1'b1);

        base = ticks_sent;
        for (int m = 0; m < 3; m++) begin
            case (m)
                0:       begin send_idle_pct = 26; recv_idle_pct = 77; end
                1:       begin send_idle_pct = 77; recv_idle_pct = 26; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            rx_hold_seq++;
            while (ticks_sent < base + (m + 1) * 600) run_random_phase();
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (trk.mismatches == 0 && trk.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/uer_pkg.sv
rtl/uer_scan.sv
rtl/ultrasonic_echo_ranger.sv
bench/tb_ultrasonic_echo_ranger.sv
